>>> rtl/bqe_pkg.sv
`timescale 1ns / 1ps
package bqe_pkg;
  localparam int DefMaxRows = 64;
  localparam int DefMaxCols = 64;
  localparam int SymW = 2;
  localparam int IdxW = 13;
  localparam int DimW = 7;

  typedef enum logic [1:0] {
    SYM_WHITE = 2'd0,
    SYM_BLACK = 2'd1,
    SYM_SPLIT = 2'd2
  } sym_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_FETCH = 1'b1
  } req_t;

  typedef enum logic [0:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_PUSH,
    ST_OUT
  } eng_state_t;
endpackage

>>> rtl/bqe_stream_if.sv
`timescale 1ns / 1ps
interface bqe_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic pixel;
  modport source (output valid, req_type, pixel, input ready);
  modport sink (input valid, req_type, pixel, output ready);
endinterface

interface bqe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  symbol;
  logic [12:0] symbol_index;
  logic        last_symbol;
  modport source (output valid, symbol, symbol_index, last_symbol, input ready);
  modport sink (input valid, symbol, symbol_index, last_symbol, output ready);
endinterface

>>> rtl/bqe_front.sv
`timescale 1ns / 1ps
// Front: accepts beats and queues them in a two-entry FIFO.
module bqe_front
  import bqe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic flush,
  bqe_in_if.sink in_ch,
  output logic q_valid,
  input  logic q_pop,
  output logic q_req,
  output logic q_pixel
);
  logic [1:0] mem_req, mem_pix;
  logic rd_ptr, wr_ptr;
  logic [1:0] count;

  assign in_ch.ready = (count != 2'd2) && !flush;
  assign q_valid = (count != 2'd0);
  assign q_req = mem_req[rd_ptr];
  assign q_pixel = mem_pix[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mem_req[wr_ptr] <= in_ch.req_type;
      mem_pix[wr_ptr] <= in_ch.pixel;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_ch.valid && in_ch.ready) - 2'(q_pop);
    end
  end
endmodule

>>> rtl/bqe_engine.sv
`timescale 1ns / 1ps
// Back: image memory, region stack and one-pixel-per-cycle scanner.
module bqe_engine
  import bqe_pkg::*;
#(
  parameter int MAX_ROWS = DefMaxRows,
  parameter int MAX_COLS = DefMaxCols
) (
  input  logic clk,
  input  logic rst,
  input  logic restart,
  input  logic [$clog2(MAX_ROWS+1)-1:0] rows,
  input  logic [$clog2(MAX_COLS+1)-1:0] cols,
  input  logic q_valid,
  input  logic q_req,
  input  logic q_pixel,
  output logic q_pop,
  bqe_out_if.source out_ch
);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(DEPTH);
  localparam int SLOTS = 3 * (RW > CW ? RW : CW) + 4;
  localparam int SPW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [RW-1:0] r0, r1;
    logic [CW-1:0] c0, c1;
  } region_t;

  logic     img [DEPTH];
  region_t  stk [SLOTS];
  logic     rd_data;

  eng_state_t state, state_next;
  logic encoding;
  logic [RW-1:0] lr;
  logic [CW-1:0] lc;
  logic [SPW-1:0] sp;
  region_t cur;
  logic [RW-1:0] sr;
  logic [CW-1:0] sc;
  logic base, split, first, rd_pend, scan_end;
  logic done_issue, rd_last;
  logic [1:0] push_step;
  logic [IdxW-1:0] emit;
  logic [RW-1:0] mr;
  logic [CW-1:0] mc;
  logic has_b, has_r;
  logic do_load, load_last;
  logic mem_we, push_we;
  logic [AW-1:0] mem_wa, mem_ra;
  region_t push_val;

  // quadrant midpoints (extra row/column to top/left)
  assign mr = cur.r0 + RW'((({1'b0, cur.r1} - {1'b0, cur.r0}) >> 1));
  assign mc = cur.c0 + CW'((({1'b0, cur.c1} - {1'b0, cur.c0}) >> 1));
  assign has_b = mr != cur.r1;
  assign has_r = mc != cur.c1;

  assign do_load = (state == ST_IDLE) && q_valid && q_req == REQ_LOAD && !encoding;
  assign load_last = ({1'b0, lr} == rows - 1) && ({1'b0, lc} == cols - 1);
  assign mem_we = do_load;
  assign mem_wa = AW'(lr) * AW'(MAX_COLS) + AW'(lc);
  assign mem_ra = AW'(sr) * AW'(MAX_COLS) + AW'(sc);
  assign scan_end = (sr == cur.r1) && (sc == cur.c1);

  // image memory
  always_ff @(posedge clk) begin
    if (mem_we) img[mem_wa] <= q_pixel;
    rd_data <= img[mem_ra];
  end

  // child region to push this cycle (reverse order)
  always_comb begin
    push_we = 1'b0;
    push_val = cur;
    if (state == ST_PUSH) begin
      unique case (push_step)
        2'd0: begin
          push_we = has_b && has_r;
          push_val = '{r0: mr + 1'b1, r1: cur.r1, c0: mc + 1'b1, c1: cur.c1};
        end
        2'd1: begin
          push_we = has_b;
          push_val = '{r0: mr + 1'b1, r1: cur.r1, c0: cur.c0, c1: mc};
        end
        2'd2: begin
          push_we = has_r;
          push_val = '{r0: cur.r0, r1: mr, c0: mc + 1'b1, c1: cur.c1};
        end
        default: begin
          push_we = 1'b1;
          push_val = '{r0: cur.r0, r1: mr, c0: cur.c0, c1: mc};
        end
      endcase
    end
  end

  // region stack
  always_ff @(posedge clk) begin
    if (push_we) stk[sp] <= push_val;
    else if (do_load && load_last)
      stk[0] <= '{r0: '0, r1: RW'(rows - 1), c0: '0, c1: CW'(cols - 1)};
  end

  // next state
  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    unique case (state)
      ST_IDLE: if (q_valid) begin
        if (q_req == REQ_LOAD || !encoding || sp == '0) q_pop = 1'b1;
        else begin
          q_pop = 1'b1;
          state_next = ST_POP;
        end
      end
      ST_POP:  state_next = ST_SCAN;
      ST_SCAN: if (rd_pend && !first && (rd_data != base)) state_next = ST_PUSH;
               else if (rd_pend && rd_last) state_next = ST_OUT;
      ST_PUSH: if (push_step == 2'd3) state_next = ST_OUT;
      ST_OUT:  if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.symbol = split ? SYM_SPLIT : (base ? SYM_BLACK : SYM_WHITE);
  assign out_ch.symbol_index = emit;
  assign out_ch.last_symbol = (sp == '0);

  // control registers
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= ST_IDLE;
      encoding <= 1'b0;
      lr <= '0;
      lc <= '0;
      sp <= '0;
      emit <= '0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (do_load) begin
        if (load_last) begin
          encoding <= 1'b1;
          sp <= SPW'(1);
          emit <= '0;
        end else if ({1'b0, lc} == cols - 1) begin
          lc <= '0;
          lr <= lr + 1'b1;
        end else lc <= lc + 1'b1;
      end
      if (state == ST_POP) begin
        cur <= stk[sp - 1'b1];
        sr <= stk[sp - 1'b1].r0;
        sc <= stk[sp - 1'b1].c0;
        sp <= sp - 1'b1;
        split <= 1'b0;
        first <= 1'b1;
        rd_pend <= 1'b0;
        done_issue <= 1'b0;
      end
      // scan: issue one address per cycle, compare its pixel the next cycle
      if (state == ST_SCAN) begin
        if (rd_pend) begin
          if (first) begin
            base <= rd_data;
            first <= 1'b0;
          end else if (rd_data != base) begin
            split <= 1'b1;
            push_step <= 2'd0;
          end
        end
        rd_pend <= !done_issue;
        rd_last <= scan_end;
        if (!done_issue) begin
          if (scan_end) done_issue <= 1'b1;
          else if (sc == cur.c1) begin
            sc <= cur.c0;
            sr <= sr + 1'b1;
          end else sc <= sc + 1'b1;
        end
      end
      if (state == ST_PUSH) begin
        push_step <= push_step + 1'b1;
        if (push_we) sp <= sp + 1'b1;
      end
      if (state == ST_OUT && out_ch.ready) begin
        emit <= emit + 1'b1;
        if (sp == '0) begin
          encoding <= 1'b0;
          lr <= '0;
          lc <= '0;
          emit <= '0;
        end
      end
    end
  end
endmodule

>>> rtl/binary_quadtree_encoder.sv
`timescale 1ns / 1ps
// Binary quadtree encoder.
// in_ch beats: req_type 0 loads the next pixel (row-major), 1 fetches a symbol.
// out_ch beats: one symbol per fetch made while encoding; last_symbol marks
// the end of the code, after which the block is back in the load phase.
// APB port: register 0 num_rows at 0x0, register 1 num_cols at 0x4. A write
// restarts loading. Values clamp to 1..MAX_ROWS/MAX_COLS.
// Flow: a load beat passes through the input queue into the image memory;
// loads stream at one beat per cycle. A fetch pops a region (ST_POP), scans it
// (ST_SCAN) one pixel per cycle through the image memory's read port, and
// shows its symbol (ST_OUT). A split stops the scan at the first differing
// pixel and pushes the quadrants that exist (ST_PUSH) before ST_OUT.
// The input queue accepts beats while a symbol waits on out_ch until both of its entries are full.
// Reset clears FSM, counters and pointers, not the image memory or the stack.
// A stalled receiver holds the symbol stable; the engine waits.
module binary_quadtree_encoder
  import bqe_pkg::*;
#(
  parameter int MAX_ROWS = DefMaxRows,
  parameter int MAX_COLS = DefMaxCols
) (
  input  logic clk,
  input  logic rst,
  bqe_in_if.sink in_ch,
  bqe_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int RB = $clog2(MAX_ROWS + 1);
  localparam int CB = $clog2(MAX_COLS + 1);

  logic [DimW-1:0] num_rows, num_cols;
  logic [RB-1:0] rows;
  logic [CB-1:0] cols;
  logic wr, q_valid, q_pop, q_req, q_pixel;
  logic [DimW-1:0] wv;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign wv = pwdata[DimW-1:0];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= DimW'(64);
      num_cols <= DimW'(64);
    end else if (wr) begin
      if (paddr[2] == REG_ROWS) num_rows <= wv;
      else num_cols <= wv;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ROWS) prdata[DimW-1:0] = num_rows;
    else prdata[DimW-1:0] = num_cols;
  end

  // clamped dimensions
  always_comb begin
    if (num_rows == '0) rows = RB'(1);
    else if (32'(num_rows) > MAX_ROWS) rows = RB'(MAX_ROWS);
    else rows = RB'(num_rows);
    if (num_cols == '0) cols = CB'(1);
    else if (32'(num_cols) > MAX_COLS) cols = CB'(MAX_COLS);
    else cols = CB'(num_cols);
  end

  bqe_front u_front (
    .clk, .rst, .flush(wr), .in_ch,
    .q_valid, .q_pop, .q_req, .q_pixel
  );

  bqe_engine #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_engine (
    .clk, .rst, .restart(wr), .rows, .cols,
    .q_valid, .q_req, .q_pixel, .q_pop, .out_ch
  );
endmodule

>>> rtl/bqe_checker.sv
`timescale 1ns / 1ps
module bqe_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] symbol,
  input logic [12:0] symbol_index,
  input logic pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol_index))
    else $error("symbol dropped while stalled");
  a_sym: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> symbol != 2'd3) else $error("bad symbol code");
  a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind binary_quadtree_encoder bqe_checker u_chk (
  .clk, .rst, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .symbol(out_ch.symbol), .symbol_index(out_ch.symbol_index), .pready
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import bqe_pkg::*;

  localparam int MaxRows = DefMaxRows;
  localparam int MaxCols = DefMaxCols;
  localparam int StackSlots = 32;
  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 50;

  typedef struct {
    sym_t        sym;
    logic [12:0] idx;
    logic        last;
  } symbol_beat_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bqe_in_if in_if();
  bqe_out_if out_if();

  binary_quadtree_encoder dut (
    .clk(clk), .rst(rst), .in_ch(in_if.sink), .out_ch(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Encoder shadow state
  logic        img [MaxRows][MaxCols];
  int          rows_cfg, cols_cfg;
  int          loaded;
  int          stk_r0 [StackSlots], stk_r1 [StackSlots];
  int          stk_c0 [StackSlots], stk_c1 [StackSlots];
  int          depth;
  logic [12:0] emitted;
  bit          encoding;

  symbol_beat_t pending_symbols[$];
  int errors;
  int symbols_seen;
  int beats_sent;
  int images_done;
  int idle_pct;
  int stall_pct;
  longint cycles;

  // Clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int clamp_dim(input logic [6:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void restart_load();
    loaded = 0;
    emitted = '0;
    depth = 0;
    encoding = 1'b0;
  endfunction

  function automatic void push_region(input int r0, input int r1, input int c0, input int c1);
    if (depth >= StackSlots) return;
    stk_r0[depth] = r0;
    stk_r1[depth] = r1;
    stk_c0[depth] = c0;
    stk_c1[depth] = c1;
    depth++;
  endfunction

  function automatic sym_t region_color(input int r0, input int r1, input int c0, input int c1);
    logic base;
    base = img[r0][c0];
    for (int r = r0; r <= r1; r++)
      for (int c = c0; c <= c1; c++)
        if (img[r][c] != base) return SYM_SPLIT;
    return base ? SYM_BLACK : SYM_WHITE;
  endfunction

  // Advance the shadow encoder by one accepted request beat
  function automatic void encoder_step(input req_t req, input logic px);
    int r0, r1, c0, c1, mr, mc;
    bit has_right, has_bottom, last;
    sym_t s;
    symbol_beat_t b;
    if (req == REQ_LOAD) begin
      if (encoding) return;
      if (loaded < rows_cfg * cols_cfg) begin
        img[loaded / cols_cfg][loaded % cols_cfg] = px;
        loaded++;
      end
      if (loaded >= rows_cfg * cols_cfg) begin
        encoding = 1'b1;
        depth = 0;
        emitted = '0;
        push_region(0, rows_cfg - 1, 0, cols_cfg - 1);
      end
      return;
    end
    if (!encoding || depth == 0) return;
    depth--;
    r0 = stk_r0[depth]; r1 = stk_r1[depth];
    c0 = stk_c0[depth]; c1 = stk_c1[depth];
    s = region_color(r0, r1, c0, c1);
    if (s == SYM_SPLIT) begin
      mr = r0 + (r1 - r0 + 2) / 2 - 1;
      mc = c0 + (c1 - c0 + 2) / 2 - 1;
      has_right = (mc + 1 <= c1);
      has_bottom = (mr + 1 <= r1);
      // reverse order so top-left comes out first
      if (has_bottom && has_right) push_region(mr + 1, r1, mc + 1, c1);
      if (has_bottom) push_region(mr + 1, r1, c0, mc);
      if (has_right) push_region(r0, mr, mc + 1, c1);
      push_region(r0, mr, c0, mc);
    end
    last = (depth == 0);
    b.sym = s;
    b.idx = emitted;
    b.last = last;
    pending_symbols.push_back(b);
    emitted = emitted + 1'b1;
    if (last) restart_load();
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  // Output side: check each beat, then pick next ready
  always @(posedge clk) begin
    symbol_beat_t e;
    if (!rst && out_if.valid && out_if.ready) begin
      symbols_seen++;
      if (pending_symbols.size() == 0) begin
        report_mismatch($sformatf("unexpected symbol %0d index %0d",
                                  out_if.symbol, out_if.symbol_index));
      end else begin
        e = pending_symbols.pop_front();
        if (out_if.symbol !== e.sym)
          report_mismatch($sformatf("symbol %0d, expected %0d at index %0d",
                                    out_if.symbol, e.sym, e.idx));
        if (out_if.symbol_index !== e.idx)
          report_mismatch($sformatf("symbol_index %0d, expected %0d",
                                    out_if.symbol_index, e.idx));
        if (out_if.last_symbol !== e.last)
          report_mismatch($sformatf("last_symbol %0b, expected %0b at index %0d",
                                    out_if.last_symbol, e.last, e.idx));
      end
    end
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Send one request beat; valid stays up between back-to-back beats
  task automatic send_beat(input req_t req, input logic px);
    if ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= req;
    in_if.pixel <= px;
    do @(posedge clk); while (!in_if.ready);
    beats_sent++;
    encoder_step(req, px);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [6:0] value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ROWS) rows_cfg = clamp_dim(value, MaxRows);
    else cols_cfg = clamp_dim(value, MaxCols);
    restart_load();
  endtask

  // Load one image and fetch its whole code. style: 0 random, 1 blocky, 2 all white,
  // 3 all black. noise adds stray fetches while loading and loads while encoding.
  task automatic encode_image(input int style, input int noise_pct,
                              input int pause_at);
    int blk;
    logic px, base;
    int n;
    n = 0;
    blk = 1 << $urandom_range(0, 3);
    base = 1'($urandom_range(1));
    for (int r = 0; r < rows_cfg; r++) begin
      for (int c = 0; c < cols_cfg; c++) begin
        case (style)
          0: px = 1'($urandom_range(1));
          1: begin
            px = base ^ (((r / blk) + (c / blk) + $urandom_range(1)) % 2 == 0 ? 1'b0 : 1'b1);
            if ($urandom_range(9) != 0) px = base ^ 1'((r / blk) % 2);
          end
          2: px = 1'b0;
          default: px = 1'b1;
        endcase
        if ($urandom_range(99) < noise_pct) send_beat(REQ_FETCH, 1'($urandom_range(1)));
        send_beat(REQ_LOAD, px);
      end
    end
    while (encoding) begin
      if ($urandom_range(99) < noise_pct) send_beat(REQ_LOAD, 1'($urandom_range(1)));
      send_beat(REQ_FETCH, 1'($urandom_range(1)));
      n++;
      // sender holds off until the checker has caught up
      if (n == pause_at) begin
        in_if.valid <= 1'b0;
        do @(posedge clk); while (pending_symbols.size() != 0);
      end
    end
    images_done++;
  endtask

  // Tall frame that keeps the reset row count
  task automatic test_full_frame();
    idle_pct = 0;
    stall_pct = 0;
    apb_write(REG_COLS, 7'd2);
    encode_image(0, 0, 40);
  endtask

  // Degenerate and odd sizes, clamping, uniform images, stray requests
  task automatic test_directed();
    apb_write(REG_ROWS, 7'd0);
    apb_write(REG_COLS, 7'd0);
    send_beat(REQ_FETCH, 1'b1);
    send_beat(REQ_LOAD, 1'b0);
    send_beat(REQ_LOAD, 1'b1);
    send_beat(REQ_FETCH, 1'b0);
    send_beat(REQ_LOAD, 1'b1);
    send_beat(REQ_FETCH, 1'b0);
    apb_write(REG_ROWS, 7'd2);
    apb_write(REG_COLS, 7'd3);
    send_beat(REQ_LOAD, 1'b1);
    send_beat(REQ_FETCH, 1'b1);
    send_beat(REQ_LOAD, 1'b0);
    send_beat(REQ_LOAD, 1'b1);
    send_beat(REQ_LOAD, 1'b0);
    send_beat(REQ_LOAD, 1'b1);
    send_beat(REQ_LOAD, 1'b1);
    send_beat(REQ_FETCH, 1'b0);
    send_beat(REQ_LOAD, 1'b0);
    while (encoding) send_beat(REQ_FETCH, 1'b1);
    // abort a half-loaded image with a register write
    send_beat(REQ_LOAD, 1'b1);
    apb_write(REG_ROWS, 7'd127);
    apb_write(REG_COLS, 7'd1);
    encode_image(0, 0, 0);
    apb_write(REG_ROWS, 7'd1);
    apb_write(REG_COLS, 7'd64);
    encode_image(0, 0, 0);
    encode_image(2, 0, 0);
    apb_write(REG_COLS, 7'd100);
    encode_image(3, 0, 0);
    apb_write(REG_ROWS, 7'd3);
    apb_write(REG_COLS, 7'd5);
    encode_image(0, 0, 0);
  endtask

  // Random small images under one idling setting
  task automatic test_random_phase(input int idle, input int stall, input int target);
    int start;
    idle_pct = idle;
    stall_pct = stall;
    start = beats_sent;
    while (beats_sent - start < target) begin
      if ($urandom_range(3) == 0) begin
        if ($urandom_range(9) == 0) apb_write(REG_ROWS, 7'($urandom_range(9, 16)));
        else apb_write(REG_ROWS, 7'($urandom_range(1, 8)));
        if ($urandom_range(9) == 0) apb_write(REG_COLS, 7'($urandom_range(9, 16)));
        else apb_write(REG_COLS, 7'($urandom_range(1, 8)));
      end
      encode_image($urandom_range(0, 3), $urandom_range(0, 1) ? 0 : 8,
                   $urandom_range(0, 6));
    end
  endtask

  initial begin
    cycles = 0;
    errors = 0;
    symbols_seen = 0;
    beats_sent = 0;
    images_done = 0;
    idle_pct = 0;
    stall_pct = 0;
    rows_cfg = clamp_dim(7'd64, MaxRows);
    cols_cfg = clamp_dim(7'd64, MaxCols);
    restart_load();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_LOAD;
    in_if.pixel = 1'b0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_full_frame();
    test_directed();
    test_random_phase(0, 0, 50);
    test_random_phase(66, 0, 50);
    test_random_phase(0, 66, 50);
    test_random_phase(30, 30, 50);

    wait_drained();
    $display("Covered %0d request beats over %0d images, %0d symbols checked",
             beats_sent, images_done, symbols_seen);
    $display("Sizes from 1x1 up to 64 rows or 64 columns incl. clamped values, stray requests and aborts");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
